// File: design/two_count_summed_area_table_top_defines.svh
// Assertion macros used by the checker file of the summed-area table block.
`ifndef TWO_COUNT_SUMMED_AREA_TABLE_TOP_DEFINES_SVH
`define TWO_COUNT_SUMMED_AREA_TABLE_TOP_DEFINES_SVH

// Implication checked in the same cycle, disabled while reset is asserted.
`define TCSAT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent, disabled while reset is asserted.
`define TCSAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tcsat_pkg.sv
// Types and constants of the two-count summed-area table block.
package tcsat_pkg;

  // Fixed field widths.
  localparam int CNT_W     = 13;
  localparam int COORD_W   = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  // Item kinds.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;

  // One input item.
  typedef struct packed {
    logic               kind;
    logic               cell_marked;
    logic [COORD_W-1:0] row_start;
    logic [COORD_W-1:0] col_start;
    logic [COORD_W-1:0] row_end;
    logic [COORD_W-1:0] col_end;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [CNT_W-1:0] marked_count;
    logic [CNT_W-1:0] unmarked_count;
    logic             query_error;
  } out_item_t;

  // One table entry: both prefix counts.
  typedef struct packed {
    logic [CNT_W-1:0] marked;
    logic [CNT_W-1:0] unmarked;
  } cnt_pair_t;

endpackage

// File: design/tcsat_in_if.sv
// Input channel: valid/ready handshake carrying one load or query item.
interface tcsat_in_if;
  import tcsat_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/tcsat_out_if.sv
// Output channel: valid/ready handshake carrying one query result item.
interface tcsat_out_if;
  import tcsat_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/two_count_summed_area_table_top.sv
// Two-count summed-area table with rectangle queries.
// Usage: configure grid_rows (index 0) and grid_cols (index 1) on the write port while
// the block is idle; any such write restarts loading. Load items then deliver the grid
// cells in raster order and produce no result. Query items name an inclusive rectangle
// and return the marked and unmarked counts inside it, or query_error with zero counts
// when the grid is not complete or the rectangle is out of range or reversed.
// Structure: the table sits in one single-port memory with a registered read, and one
// shared add/subtract unit does all the counting under a small sequencer. A load of the
// first row writes its entry directly; a later load reads the entry above, then writes.
// A valid query does four reads, four accumulate steps and a result hand-off; an
// erroneous query only the hand-off. The input is not ready while an item is worked on.
// Results go to an output register; the next item is accepted while a result waits.
// A query that finishes while the previous result is still unread holds until the
// receiver takes it. Reset empties the output register, sets both sizes to 64 (or
// MAX_DIM if smaller) and restarts loading; the table memory itself is not cleared.
module two_count_summed_area_table_top #(
  parameter int MAX_DIM = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcsat_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tcsat_pkg::CFG_W-1:0]     cfg_data_i,
  tcsat_in_if.sink                       in_i,
  tcsat_out_if.source                    out_o
);
  import tcsat_pkg::*;

  localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW    = 2 * DW;
  localparam int DEPTH = 1 << AW;

  // Size after reset: 64, limited to the table size.
  localparam logic [CFG_W-1:0] SIZE_RST = CFG_W'((MAX_DIM < 64) ? MAX_DIM : 64);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LD_RD = 4'd1;
  localparam logic [3:0] ST_LD_WR = 4'd2;
  localparam logic [3:0] ST_QA    = 4'd3;
  localparam logic [3:0] ST_QB    = 4'd4;
  localparam logic [3:0] ST_QC    = 4'd5;
  localparam logic [3:0] ST_QD    = 4'd6;
  localparam logic [3:0] ST_QE    = 4'd7;
  localparam logic [3:0] ST_RES   = 4'd8;

  // Control state.
  logic [3:0]       state_q, state_d;
  logic [CFG_W-1:0] grid_rows_q, grid_rows_d;
  logic [CFG_W-1:0] grid_cols_q, grid_cols_d;
  logic [CFG_W-1:0] run_m_q, run_m_d;
  logic [CFG_W-1:0] run_u_q, run_u_d;
  logic [DW-1:0]    load_row_q, load_row_d;
  logic [DW-1:0]    load_col_q, load_col_d;
  logic             complete_q, complete_d;
  logic             out_valid_q, out_valid_d;

  // Item payload registers.
  logic [DW-1:0]    q_r1_q, q_r1_d;
  logic [DW-1:0]    q_c1_q, q_c1_d;
  logic [DW-1:0]    q_r0m_q, q_r0m_d;
  logic [DW-1:0]    q_c0m_q, q_c0m_d;
  logic             r0_nz_q, r0_nz_d;
  logic             c0_nz_q, c0_nz_d;
  logic             ld_up_q, ld_up_d;
  cnt_pair_t        acc_q, acc_d;
  logic             err_q, err_d;
  out_item_t        out_data_q, out_data_d;

  // Memory port and shared arithmetic unit.
  cnt_pair_t        mem_q [DEPTH];
  cnt_pair_t        rdata_q;
  logic [AW-1:0]    mem_addr;
  logic             mem_we;
  logic             mem_re;
  cnt_pair_t        alu_a;
  cnt_pair_t        alu_b;
  logic             alu_sub;
  cnt_pair_t        alu_res;

  logic             in_acc;
  logic             q_bad;
  logic [CFG_W-1:0] cfg_clamped;
  logic [DW:0]      col_inc;
  logic [DW:0]      row_inc;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // Shared add/subtract unit working on both counts at once.
  always_comb begin
    if (alu_sub) begin
      alu_res.marked   = alu_a.marked - alu_b.marked;
      alu_res.unmarked = alu_a.unmarked - alu_b.unmarked;
    end else begin
      alu_res.marked   = alu_a.marked + alu_b.marked;
      alu_res.unmarked = alu_a.unmarked + alu_b.unmarked;
    end
  end

  // A size register reads 0 as 1 and anything above the table size as the table size.
  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_clamped = CFG_W'(1);
    end else if (int'(cfg_data_i) > MAX_DIM) begin
      cfg_clamped = CFG_W'(MAX_DIM);
    end else begin
      cfg_clamped = cfg_data_i;
    end
  end

  // Rectangle check done at acceptance.
  assign q_bad = !complete_q
              || (CFG_W'(in_i.data.row_end) >= grid_rows_q)
              || (CFG_W'(in_i.data.col_end) >= grid_cols_q)
              || (in_i.data.row_start > in_i.data.row_end)
              || (in_i.data.col_start > in_i.data.col_end);

  assign col_inc = {1'b0, load_col_q} + 1'b1;
  assign row_inc = {1'b0, load_row_q} + 1'b1;

  // Sequencer: drives the memory port and the arithmetic unit step by step.
  always_comb begin
    state_d     = state_q;
    grid_rows_d = grid_rows_q;
    grid_cols_d = grid_cols_q;
    run_m_d     = run_m_q;
    run_u_d     = run_u_q;
    load_row_d  = load_row_q;
    load_col_d  = load_col_q;
    complete_d  = complete_q;
    out_valid_d = out_valid_q;
    q_r1_d      = q_r1_q;
    q_c1_d      = q_c1_q;
    q_r0m_d     = q_r0m_q;
    q_c0m_d     = q_c0m_q;
    r0_nz_d     = r0_nz_q;
    c0_nz_d     = c0_nz_q;
    ld_up_d     = ld_up_q;
    acc_d       = acc_q;
    err_d       = err_q;
    out_data_d  = out_data_q;
    mem_addr    = {q_r1_q, q_c1_q};
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    alu_a       = acc_q;
    alu_b       = rdata_q;
    alu_sub     = 1'b0;

    // The receiver taking the held result frees the output register.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.data.kind == KIND_QUERY) begin
            q_r1_d  = DW'(in_i.data.row_end);
            q_c1_d  = DW'(in_i.data.col_end);
            q_r0m_d = DW'(in_i.data.row_start - 1'b1);
            q_c0m_d = DW'(in_i.data.col_start - 1'b1);
            r0_nz_d = (in_i.data.row_start != '0);
            c0_nz_d = (in_i.data.col_start != '0);
            if (q_bad) begin
              acc_d   = '0;
              err_d   = 1'b1;
              state_d = ST_RES;
            end else begin
              err_d   = 1'b0;
              state_d = ST_QA;
            end
          end else if (!complete_q) begin
            // Running row counts restart at the first column.
            if (load_col_q == '0) begin
              run_m_d = CFG_W'(in_i.data.cell_marked);
              run_u_d = CFG_W'(!in_i.data.cell_marked);
            end else begin
              run_m_d = run_m_q + CFG_W'(in_i.data.cell_marked);
              run_u_d = run_u_q + CFG_W'(!in_i.data.cell_marked);
            end
            ld_up_d = (load_row_q != '0);
            state_d = (load_row_q != '0) ? ST_LD_RD : ST_LD_WR;
          end
        end
      end
      ST_LD_RD: begin
        // Fetch the entry directly above the cell.
        mem_addr = {DW'(load_row_q - 1'b1), load_col_q};
        mem_re   = 1'b1;
        state_d  = ST_LD_WR;
      end
      ST_LD_WR: begin
        // Entry = entry above + running row counts.
        alu_a        = ld_up_q ? rdata_q : '0;
        alu_b.marked   = CNT_W'(run_m_q);
        alu_b.unmarked = CNT_W'(run_u_q);
        mem_addr     = {load_row_q, load_col_q};
        mem_we       = 1'b1;
        if (col_inc >= grid_cols_q) begin
          load_col_d = '0;
          if (row_inc >= grid_rows_q) begin
            load_row_d = '0;
            complete_d = 1'b1;
          end else begin
            load_row_d = DW'(row_inc);
          end
        end else begin
          load_col_d = DW'(col_inc);
        end
        state_d = ST_IDLE;
      end
      ST_QA: begin
        mem_addr = {q_r1_q, q_c1_q};
        mem_re   = 1'b1;
        state_d  = ST_QB;
      end
      ST_QB: begin
        alu_a    = '0;
        acc_d    = alu_res;
        mem_addr = {q_r0m_q, q_c1_q};
        mem_re   = 1'b1;
        state_d  = ST_QC;
      end
      ST_QC: begin
        // Remove the strip above the rectangle.
        alu_sub  = 1'b1;
        acc_d    = r0_nz_q ? alu_res : acc_q;
        mem_addr = {q_r1_q, q_c0m_q};
        mem_re   = 1'b1;
        state_d  = ST_QD;
      end
      ST_QD: begin
        // Remove the strip left of the rectangle.
        alu_sub  = 1'b1;
        acc_d    = c0_nz_q ? alu_res : acc_q;
        mem_addr = {q_r0m_q, q_c0m_q};
        mem_re   = 1'b1;
        state_d  = ST_QE;
      end
      ST_QE: begin
        // Add back the corner removed twice.
        acc_d   = (r0_nz_q && c0_nz_q) ? alu_res : acc_q;
        state_d = ST_RES;
      end
      ST_RES: begin
        if (!out_valid_q || out_o.ready) begin
          out_data_d.marked_count   = acc_q.marked;
          out_data_d.unmarked_count = acc_q.unmarked;
          out_data_d.query_error    = err_q;
          out_valid_d               = 1'b1;
          state_d                   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A size write restarts loading.
    if (cfg_we_i && (cfg_idx_i == CFG_GRID_ROWS || cfg_idx_i == CFG_GRID_COLS)) begin
      if (cfg_idx_i == CFG_GRID_ROWS) begin
        grid_rows_d = cfg_clamped;
      end else begin
        grid_cols_d = cfg_clamped;
      end
      run_m_d    = '0;
      run_u_d    = '0;
      load_row_d = '0;
      load_col_d = '0;
      complete_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      grid_rows_q <= SIZE_RST;
      grid_cols_q <= SIZE_RST;
      run_m_q     <= '0;
      run_u_q     <= '0;
      load_row_q  <= '0;
      load_col_q  <= '0;
      complete_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      grid_rows_q <= grid_rows_d;
      grid_cols_q <= grid_cols_d;
      run_m_q     <= run_m_d;
      run_u_q     <= run_u_d;
      load_row_q  <= load_row_d;
      load_col_q  <= load_col_d;
      complete_q  <= complete_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    q_r1_q     <= q_r1_d;
    q_c1_q     <= q_c1_d;
    q_r0m_q    <= q_r0m_d;
    q_c0m_q    <= q_c0m_d;
    r0_nz_q    <= r0_nz_d;
    c0_nz_q    <= c0_nz_d;
    ld_up_q    <= ld_up_d;
    acc_q      <= acc_d;
    err_q      <= err_d;
    out_data_q <= out_data_d;
  end

  // Table memory: one port, registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= alu_res;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

endmodule

// File: design/tcsat_checker.sv
// Port-level checker for the summed-area table block, with its bind statement.
`include "two_count_summed_area_table_top_defines.svh"

module tcsat_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 in_kind_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input tcsat_pkg::out_item_t out_item_i
);
  import tcsat_pkg::*;

  // A stalled result holds its value.
  `TCSAT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_item_i), "result changed while stalled")

  // An error result never carries counts.
  `TCSAT_ASSERT_SAME(a_err_zero, clk_i, rst_ni, out_valid_i && out_item_i.query_error, out_item_i.marked_count == '0 && out_item_i.unmarked_count == '0, "error result with counts")

  // An accepted query keeps the input closed in the next cycle.
  `TCSAT_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, in_valid_i && in_ready_i && in_kind_i == KIND_QUERY, !in_ready_i, "input ready right after a query")

  // A new result only appears at the end of query work, not from the idle state.
  `TCSAT_ASSERT_SAME(a_res_from_busy, clk_i, rst_ni, $rose(out_valid_i), $past(!in_ready_i), "result appeared while idle")

endmodule

bind two_count_summed_area_table_top tcsat_checker u_tcsat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_kind_i   (in_i.data.kind),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.data)
);
